// ----- design/skt_pkg.sv -----
package skt_pkg;

    // Request codes carried in the slave-side tuser
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // Result status codes carried in the master-side tuser
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Field widths fixed by the stream format
    localparam int REQ_W   = 2;
    localparam int KEY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture an accepted request
        logic compare;  // evaluate every cell against the request key
        logic commit;   // apply the update and load the result register
    } t_cmd;

endpackage

// ----- design/skt_ctrl.sv -----
module skt_ctrl
    import skt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_commit;

    // Commit only when the result register is free or being drained
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || i_m_tready);

    assign o_s_tready    = (r_state == S_IDLE);
    assign o_m_tvalid    = r_out_valid;
    assign o_cmd.load    = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.commit  = w_commit;

    // Sequence one request through compare and update
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_commit) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the result-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- design/skt_datapath.sv -----
module skt_datapath
    import skt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [KEY_W-1:0]   i_key,
    output logic [STAT_W-1:0]  o_status,
    output logic [POS_W-1:0]   o_position,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int CW = $clog2(ENTRIES + 1);

    logic [KEY_BITS-1:0] r_cell [ENTRIES];
    logic [KEY_BITS-1:0] n_cell [ENTRIES];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [REQ_W-1:0]    r_req;
    logic [KEY_BITS-1:0] r_key;
    logic [ENTRIES-1:0]  r_lt;
    logic [ENTRIES-1:0]  r_le;
    logic                r_hit;
    logic [ENTRIES-1:0]  w_valid;
    logic [ENTRIES-1:0]  w_eq;
    logic [ENTRIES-1:0]  w_le_prev;
    logic [ENTRIES:0]    w_lt_ext;
    logic [ENTRIES:0]    w_le_ext;
    logic [CW-1:0]       w_pos_lt;
    logic [CW-1:0]       w_pos_le;
    logic [STAT_W-1:0]   n_status;
    logic [CW-1:0]       n_pos;
    logic [STAT_W-1:0]   r_status;
    logic [CW-1:0]       r_pos;
    logic                w_full;

    // Mark the occupied prefix of the table
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_valid[i] = (CW'(i) < r_count);
        end
    end

    // Equality of every cell with the request key, used for the hit flag
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_eq[i] = (r_cell[i] == r_key);
        end
    end

    // Capture the request and compare every cell in parallel
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_key <= KEY_BITS'(i_key);
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_lt[i] <= w_valid[i] && (r_cell[i] < r_key);
                r_le[i] <= w_valid[i] && (r_cell[i] <= r_key);
            end
            r_hit <= |(w_valid & w_eq);
        end
    end

    // Turn the thermometer flags into an index: the count of ones
    assign w_lt_ext  = {1'b0, r_lt};
    assign w_le_ext  = {1'b0, r_le};
    assign w_le_prev = {r_le[ENTRIES-2:0], 1'b1};

    always_comb begin
        w_pos_lt = '0;
        w_pos_le = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_lt_ext[i] && !w_lt_ext[i+1]) begin
                w_pos_lt = w_pos_lt | CW'(i + 1);
            end
            if (w_le_ext[i] && !w_le_ext[i+1]) begin
                w_pos_le = w_pos_le | CW'(i + 1);
            end
        end
    end

    assign w_full = (r_count == CW'(ENTRIES));

    // Shift cells and work out the result
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_cell[i] = r_cell[i];
        end
        n_count  = r_count;
        n_status = ST_MISS;
        n_pos    = '0;
        case (r_req)
            REQ_LOOKUP: begin
                if (r_hit) begin
                    n_status = ST_OK;
                    n_pos    = w_pos_lt;
                end
            end
            REQ_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!r_le[i]) begin
                            if (w_le_prev[i]) begin
                                n_cell[i] = r_key;
                            end else begin
                                n_cell[i] = r_cell[(i + ENTRIES - 1) % ENTRIES];
                            end
                        end
                    end
                    n_count  = r_count + 1'b1;
                    n_status = ST_OK;
                    n_pos    = w_pos_le;
                end
            end
            REQ_DELETE: begin
                if (r_hit) begin
                    for (int i = 0; i < ENTRIES - 1; i++) begin
                        if (!r_lt[i]) begin
                            n_cell[i] = r_cell[i+1];
                        end
                    end
                    n_count  = r_count - 1'b1;
                    n_status = ST_OK;
                    n_pos    = w_pos_lt;
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    // Hold the table contents and the result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_cell[i] <= n_cell[i];
            end
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

    // Hold the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign o_status      = r_status;
    assign o_position    = POS_W'(r_pos);
    assign o_entry_count = COUNT_W'(r_count);

endmodule

// ----- design/sorted_key_table.sv -----
// Sorted key table: holds up to ENTRIES unsigned keys in ascending order with a fill count.
// Each request on the slave stream looks up, inserts (after equal keys) or deletes (first
// match) one key and yields exactly one result carrying a status, the index involved and the
// count after the request. The result is registered and offered once the update commits,
// and a new request is taken only after the last one is through: the idle state in which it
// is captured, one in which every cell compares itself with the key in parallel, and one in
// which the cells shift against their neighbors and the result register loads. The result
// register frees the input while a result waits; a result not yet taken holds the update of
// the next request. Table contents are undefined after reset; only the count is cleared.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [31:0] key
    input  logic [REQ_W-1:0]      i_s_tuser,   // [1:0] req_type
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [3:0] position, [8:4] entry_count
    output logic [STAT_W-1:0]     o_m_tuser    // [1:0] status
);

    t_cmd               w_cmd;
    logic [POS_W-1:0]   w_position;
    logic [COUNT_W-1:0] w_entry_count;

    skt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    skt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (i_s_tuser),
        .i_key         (i_s_tdata),
        .o_status      (o_m_tuser),
        .o_position    (w_position),
        .o_entry_count (w_entry_count)
    );

    // Pack the result fields, padded to whole bytes
    assign o_m_tdata = {{(OUT_DATA_W - POS_W - COUNT_W){1'b0}}, w_entry_count, w_position};

endmodule

// ----- design/skt_checker.sv -----
module skt_checker
    import skt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [STAT_W-1:0]     o_m_tuser
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // An accepted request keeps the input closed while it is worked on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready ##1 !o_s_tready)
        else $error("request accepted during compare or update");

    // A full refusal reports a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FULL) |-> (o_m_tdata[8:4] == COUNT_W'(ENTRIES)))
        else $error("table full reported with a count below capacity");

    // The count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8:4] <= COUNT_W'(ENTRIES)))
        else $error("entry count beyond capacity");

endmodule

bind sorted_key_table skt_checker #(.ENTRIES(ENTRIES)) u_skt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- tb/sorted_key_table_checker.sv -----
// Watches both streams of the sorted key table, keeps its own ordered copy of the keys,
// and compares every result against the oldest prediction.
module sorted_key_table_checker
    import skt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [31:0] key
    input  logic [REQ_W-1:0]      i_s_tuser,   // [1:0] req_type
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // [3:0] position, [8:4] entry_count
    input  logic [STAT_W-1:0]     i_m_tuser,   // [1:0] status
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int SLOTS = 16;
    localparam int MAX_PRINTS = 30;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
    } key_answer_t;

    logic [KEY_W-1:0] held_keys [SLOTS];
    int               held_count = 0;
    key_answer_t      answers_due [$];
    key_answer_t      oldest;
    int               fails = 0;
    int               checked = 0;

    // First slot whose key is not below k
    function automatic int first_not_below(logic [KEY_W-1:0] k);
        int i;
        i = 0;
        while (i < held_count && held_keys[i] < k)
            i++;
        return i;
    endfunction

    // First slot whose key is above k
    function automatic int first_above(logic [KEY_W-1:0] k);
        int i;
        i = 0;
        while (i < held_count && held_keys[i] <= k)
            i++;
        return i;
    endfunction

    // Apply one request to the shadow table and return the answer it must produce
    function automatic key_answer_t apply_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] k);
        key_answer_t a;
        int          p;
        int          i;
        a.status   = ST_MISS;
        a.position = '0;
        case (req)
            REQ_LOOKUP: begin
                p = first_not_below(k);
                if (p < held_count && held_keys[p] == k) begin
                    a.status   = ST_OK;
                    a.position = POS_W'(p);
                end
            end
            REQ_INSERT: begin
                if (held_count >= SLOTS) begin
                    a.status = ST_FULL;
                end else begin
                    p = first_above(k);
                    for (i = held_count; i > p; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[p] = k;
                    held_count++;
                    a.status   = ST_OK;
                    a.position = POS_W'(p);
                end
            end
            REQ_DELETE: begin
                p = first_not_below(k);
                if (p < held_count && held_keys[p] == k) begin
                    for (i = p; i + 1 < held_count; i++)
                        held_keys[i] = held_keys[i+1];
                    held_count--;
                    a.status   = ST_OK;
                    a.position = POS_W'(p);
                end
            end
            default: ;  // unused code: nothing changes
        endcase
        a.entry_count = COUNT_W'(held_count);
        return a;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        if (fails < MAX_PRINTS)
            $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
        fails++;
    endtask

    // Predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                answers_due.push_back(apply_request(i_s_tuser, i_s_tdata[KEY_W-1:0]));
            if (i_m_tvalid && i_m_tready) begin
                checked++;
                if (answers_due.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, 1);
                end else begin
                    oldest = answers_due.pop_front();
                    if (i_m_tuser != oldest.status)
                        report_mismatch("status", int'(oldest.status), int'(i_m_tuser));
                    if (i_m_tdata[POS_W-1:0] != oldest.position)
                        report_mismatch("position", int'(oldest.position),
                                        int'(i_m_tdata[POS_W-1:0]));
                    if (i_m_tdata[POS_W +: COUNT_W] != oldest.entry_count)
                        report_mismatch("entry_count", int'(oldest.entry_count),
                                        int'(i_m_tdata[POS_W +: COUNT_W]));
                end
                if (i_m_tdata[OUT_DATA_W-1:POS_W+COUNT_W] != '0)
                    report_mismatch("tdata padding", 0,
                                    int'(i_m_tdata[OUT_DATA_W-1:POS_W+COUNT_W]));
            end
        end
        o_pending    <= answers_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ----- tb/sorted_key_table_tb.sv -----
// Drives lookup, insert and delete requests into the sorted key table with random gaps
// and back-pressure; the checker beside the block predicts and compares every result.
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 100;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 10;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;   // [31:0] key
    logic [REQ_W-1:0]      i_s_tuser  = '0;   // [1:0] req_type
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // [3:0] position, [8:4] entry_count
    logic [STAT_W-1:0]     o_m_tuser;         // [1:0] status

    int fail_count;
    int pending;
    int checked;

    logic sender_gaps    = 1'b1;
    logic receiver_stall = 1'b1;
    int   stall_left     = 0;
    int   cycles         = 0;
    int   sent_by_req [4] = '{0, 0, 0, 0};

    logic [KEY_W-1:0] key_pool [8];

    sorted_key_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    sorted_key_table_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold off the result side for a random number of cycles after each result
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready)
            stall_left = receiver_stall ? $urandom_range(0, 7) : 0;
        else if (stall_left > 0)
            stall_left--;
        i_m_tready <= (stall_left == 0);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] k);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= k;
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        sent_by_req[req]++;
    endtask

    // Stop sending until every predicted result has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic refresh_pool();
        int j;
        for (j = 0; j < 8; j++) begin
            case ($urandom_range(0, 4))
                0:       key_pool[j] = '0;
                1:       key_pool[j] = '1;
                2:       key_pool[j] = KEY_W'($urandom_range(0, 15));
                default: key_pool[j] = $urandom();
            endcase
        end
    endtask

    initial begin
        int phase;
        int n;
        int pick;
        int ins_pct;
        int del_pct;
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] k;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: misses everywhere, unused code leaves the count alone
        send_request(REQ_LOOKUP, 32'h0000_0005);
        send_request(REQ_DELETE, 32'h0000_0005);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF);

        // Extremes and a duplicate that lands after its twin
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_LOOKUP, 32'h0000_0000);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'h8000_0000);

        // Fill to capacity, then refuse one more
        for (n = 0; n < 13; n++)
            send_request(REQ_INSERT, 32'h1357_9BDF ^ (32'h1111_1111 * n));
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_UNUSED, 32'h0000_0000);

        // Delete the first and last keys, then look up the surviving duplicate
        send_request(REQ_DELETE, 32'h0000_0000);
        send_request(REQ_DELETE, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'h0000_0000);
        drain_results();

        // Random phases that alternately fill, drain and churn the table
        for (phase = 0; phase < PHASES; phase++) begin
            refresh_pool();
            sender_gaps    <= (phase % 4 != 1);
            receiver_stall <= (phase % 4 != 2);
            case (phase % 3)
                0: begin ins_pct = 60; del_pct = 15; end
                1: begin ins_pct = 15; del_pct = 55; end
                default: begin ins_pct = 35; del_pct = 35; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    req = REQ_UNUSED;
                else if (pick < 3 + ins_pct)
                    req = REQ_INSERT;
                else if (pick < 3 + ins_pct + del_pct)
                    req = REQ_DELETE;
                else
                    req = REQ_LOOKUP;
                k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom();
                send_request(req, k);
            end
            if (phase == PHASES / 2)
                drain_results();
        end

        // Let the last results out, then a few more cycles for stray ones
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Requests: %0d lookups, %0d inserts, %0d deletes, %0d unused codes",
                 sent_by_req[REQ_LOOKUP], sent_by_req[REQ_INSERT],
                 sent_by_req[REQ_DELETE], sent_by_req[REQ_UNUSED]);
        $display("Results compared: %0d, under random gaps and back-pressure", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
